>>> sv/rmsd_pkg.sv
// Package for the running statistics block: controller states and command/status bundles.
// Depends on nothing; used by the controller, the datapath and the top level.
package rmsd_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_UPDATE,
    ST_MEAN_DIV,
    ST_M2_MUL,
    ST_M2_DIV,
    ST_M2_ACC,
    ST_AVG_DIV,
    ST_VAR_DIV,
    ST_SQRT,
    ST_OUTPUT
  } rmsd_state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic update;
    logic mean_start;
    logic mul_start;
    logic m2_start;
    logic m2_acc;
    logic avg_start;
    logic var_start;
    logic sqrt_start;
    logic load_out;
  } rmsd_cmd_t;

  typedef struct packed {
    logic dropped;
    logic busy;
  } rmsd_status_t;

endpackage

>>> sv/rmsd_if.sv
// Valid/ready channel carrying one beat of payload of a given type.
// Depends on nothing.
interface rmsd_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/rmsd_ctrl.sv
// Controller for the running statistics block: sequences the datapath for one beat.
// Depends on rmsd_pkg.
module rmsd_ctrl
  import rmsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_mode,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output rmsd_cmd_t    cmd,
  input  rmsd_status_t status
);

  rmsd_state_t state, state_next;
  logic        out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = in_mode ? ST_CLEAR : ST_UPDATE;
      end
      ST_CLEAR:    state_next = ST_AVG_DIV;
      ST_UPDATE:   state_next = status.dropped ? ST_AVG_DIV : ST_MEAN_DIV;
      ST_MEAN_DIV: if (!status.busy) state_next = ST_M2_MUL;
      ST_M2_MUL:   if (!status.busy) state_next = ST_M2_DIV;
      ST_M2_DIV:   if (!status.busy) state_next = ST_M2_ACC;
      ST_M2_ACC:   state_next = ST_AVG_DIV;
      ST_AVG_DIV:  if (!status.busy) state_next = ST_VAR_DIV;
      ST_VAR_DIV:  if (!status.busy) state_next = ST_SQRT;
      ST_SQRT:     if (!status.busy) state_next = ST_OUTPUT;
      ST_OUTPUT:   if (!out_full || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Each long step gets a one-cycle start pulse on entry; busy is sampled afterwards.
  rmsd_state_t prev;
  always_ff @(posedge clk) begin
    if (rst) prev <= ST_IDLE;
    else     prev <= state;
  end

  always_comb begin
    cmd = '0;
    out_full_next = out_full && !out_ready;
    unique case (state)
      ST_IDLE:     cmd.capture = in_valid;
      ST_CLEAR:    cmd.clear = 1'b1;
      ST_UPDATE:   cmd.update = 1'b1;
      ST_MEAN_DIV: cmd.mean_start = (prev != ST_MEAN_DIV);
      ST_M2_MUL:   cmd.mul_start = (prev != ST_M2_MUL);
      ST_M2_DIV:   cmd.m2_start = (prev != ST_M2_DIV);
      ST_M2_ACC:   cmd.m2_acc = 1'b1;
      ST_AVG_DIV:  cmd.avg_start = (prev != ST_AVG_DIV);
      ST_VAR_DIV:  cmd.var_start = (prev != ST_VAR_DIV);
      ST_SQRT:     cmd.sqrt_start = (prev != ST_SQRT);
      ST_OUTPUT: begin
        if (!out_full || out_ready) begin
          cmd.load_out  = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/rmsd_dp.sv
// Datapath for the running statistics block: state registers, a shared restoring
// divider, a multiplier sequenced over partial products and a bit-pair square root.
// Depends on rmsd_pkg.
module rmsd_dp
  import rmsd_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int COUNT_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rmsd_cmd_t                cmd,
  output rmsd_status_t             status,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [COUNT_BITS-1:0]    sample_count,
  output logic signed [SAMPLE_BITS-1:0] minimum,
  output logic signed [SAMPLE_BITS-1:0] maximum,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic [SAMPLE_BITS-2:0]   std_dev,
  output logic                     overflow
);

  localparam int MX   = (SAMPLE_BITS <= 46) ? 16 : (62 - SAMPLE_BITS);
  localparam int DW   = 128;               // dividend width
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic signed [63:0] SMAXV = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SMINV = -SMAXV - 64'sd1;

  logic [COUNT_BITS-1:0]         count;
  logic signed [SAMPLE_BITS-1:0] min_r, max_r;
  logic signed [63:0]            sum_r;
  logic signed [63:0]            mean_r;
  logic [63:0]                   m2_r;
  logic                          ovf_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  logic                          step_neg;
  logic [63:0]                   step_mag;
  logic [127:0]                  prod;
  logic [127:0]                  p_full;

  // The sample is held from the accepting edge, since the input may move on.
  always_ff @(posedge clk) begin
    if (cmd.capture) sample_r <= sample;
  end

  // ---------- shared divider: 128 by 64 restoring, one bit a cycle ----------
  logic [DW-1:0]  dv_q;
  logic [64:0]    dv_r;
  logic [63:0]    dv_d;
  logic [7:0]     dv_cnt;
  logic           dv_busy;
  logic           dv_start;
  logic [DW-1:0]  dv_num;
  logic [63:0]    dv_den;
  logic [64:0]    dv_trial;

  assign dv_start = cmd.mean_start | cmd.m2_start | cmd.avg_start | cmd.var_start;

  logic           sum_neg;
  logic [63:0]    sum_mag;
  assign sum_neg = sum_r < 0;
  assign sum_mag = sum_neg ? (64'd0 - $unsigned(sum_r)) : $unsigned(sum_r);

  always_comb begin
    dv_num = '0;
    dv_den = 64'(count);
    if (cmd.mean_start)     dv_num = {64'd0, step_mag};
    else if (cmd.m2_start)  dv_num = p_full;
    else if (cmd.avg_start) dv_num = {64'd0, sum_mag};
    else if (cmd.var_start) begin
      dv_num = {64'd0, m2_r};
      dv_den = 64'(count) - 64'd1;
    end
  end

  assign dv_trial = {dv_r[63:0], dv_q[DW-1]} - {1'b0, dv_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_cnt  <= '0;
    end else if (dv_start) begin
      dv_busy <= 1'b1;
      dv_cnt  <= 8'(DW);
      dv_q    <= dv_num;
      dv_r    <= '0;
      dv_d    <= (dv_den == 64'd0) ? 64'd1 : dv_den;
    end else if (dv_busy) begin
      if (!dv_trial[64]) begin
        dv_r <= dv_trial;
        dv_q <= {dv_q[DW-2:0], 1'b1};
      end else begin
        dv_r <= {dv_r[63:0], dv_q[DW-1]};
        dv_q <= {dv_q[DW-2:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 8'd1;
      if (dv_cnt == 8'd1) dv_busy <= 1'b0;
    end
  end

  // ---------- multiplier: 64x64 as four 32x32 partial products ----------
  logic [1:0]  mu_idx;
  logic        mu_busy;
  logic [63:0] mu_pp;
  logic [31:0] mu_a, mu_b;

  always_comb begin
    mu_a = mu_idx[1] ? step_mag[63:32] : step_mag[31:0];
    mu_b = mu_idx[0] ? step_mag[63:32] : step_mag[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_busy <= 1'b0;
      mu_idx  <= '0;
    end else if (cmd.mul_start) begin
      mu_busy <= 1'b1;
      mu_idx  <= '0;
      prod    <= '0;
      mu_pp   <= '0;
    end else if (mu_busy) begin
      mu_pp  <= mu_a * mu_b;
      mu_idx <= mu_idx + 2'd1;
      // Accumulate the product registered on the previous cycle.
      unique case (mu_idx)
        2'd0: ;
        2'd1: prod <= prod + {64'd0, mu_pp};
        2'd2: prod <= prod + {32'd0, mu_pp, 32'd0};
        2'd3: prod <= prod + {32'd0, mu_pp, 32'd0};
        default: ;
      endcase
      if (mu_idx == 2'd3) mu_busy <= 1'b0;
    end else if (mu_idx == 2'd0 && mu_pp != 64'd0) begin
      prod  <= prod + {mu_pp, 64'd0};
      mu_pp <= '0;
    end
  end

  assign p_full = prod >> (2 * MX);

  // ---------- square root: two bits of operand a cycle ----------
  logic [63:0] sq_v, sq_res, sq_bit;
  logic        sq_busy;
  logic [64:0] sq_try;
  assign sq_try = {1'b0, sq_res} + {1'b0, sq_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_busy <= 1'b1;
      sq_v    <= dv_q[63:0];
      sq_res  <= '0;
      sq_bit  <= 64'd1 << 62;
    end else if (sq_busy) begin
      if ({1'b0, sq_v} >= sq_try) begin
        sq_v   <= sq_v - sq_try[63:0];
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
      if (sq_bit[0]) sq_busy <= 1'b0;
    end
  end

  assign status.busy = dv_busy | mu_busy | sq_busy | dv_start | cmd.mul_start |
                       cmd.sqrt_start;
  assign status.dropped = (count == CMAX);

  // ---------- state update ----------
  logic signed [63:0] x64, sum_add, mean_step;
  logic [63:0]        m2_inc, m2_new;
  logic [63:0]        ih;
  logic               m2_carry;
  assign x64      = 64'(sample_r);
  assign sum_add  = sum_r + x64;
  assign mean_step = (x64 <<< MX) - mean_r;
  assign m2_inc   = p_full[63:0] - dv_q[63:0];
  assign ih       = p_full[127:64] - dv_q[127:64] - 64'(p_full[63:0] < dv_q[63:0]);
  assign {m2_carry, m2_new} = {1'b0, m2_r} + {1'b0, m2_inc};

  logic        avg_neg;
  logic [63:0] avg_q;
  logic        cnt_nz, cnt_gt1;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count  <= '0;
      min_r  <= SAMPLE_BITS'(SMAXV);
      max_r  <= SAMPLE_BITS'(SMINV);
      sum_r  <= '0;
      mean_r <= '0;
      m2_r   <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.update) begin
      if (count == CMAX) begin
        ovf_r <= 1'b1;
      end else begin
        if (sample_r < min_r) min_r <= sample_r;
        if (sample_r > max_r) max_r <= sample_r;
        count <= count + 1'b1;
        if (x64 > 0 && sum_add < sum_r) begin
          sum_r <= 64'sh7FFF_FFFF_FFFF_FFFF;
          ovf_r <= 1'b1;
        end else if (x64 < 0 && sum_add > sum_r) begin
          sum_r <= 64'sh8000_0000_0000_0000;
          ovf_r <= 1'b1;
        end else begin
          sum_r <= sum_add;
        end
        step_neg <= mean_step < 0;
        step_mag <= (mean_step < 0) ? (64'd0 - $unsigned(mean_step)) : $unsigned(mean_step);
      end
    end else if (cmd.m2_start) begin
      // The mean quotient sits in the divider until the next start; fold it now.
      mean_r <= step_neg ? mean_r - $signed(dv_q[63:0]) : mean_r + $signed(dv_q[63:0]);
    end else if (cmd.m2_acc) begin
      if (ih != 64'd0 || m2_carry) begin
        m2_r  <= '1;
        ovf_r <= 1'b1;
      end else begin
        m2_r <= m2_new;
      end
    end
  end

  // Average quotient is captured when the variance divide starts.
  always_ff @(posedge clk) begin
    if (cmd.var_start) begin
      avg_neg <= sum_neg;
      avg_q   <= dv_q[63:0];
    end
  end

  assign cnt_nz  = count != '0;
  assign cnt_gt1 = count > COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_count <= count;
      minimum      <= min_r;
      maximum      <= max_r;
      overflow     <= ovf_r;
      if (!cnt_nz) average <= '0;
      else if (avg_neg)
        average <= (avg_q > $unsigned(SMAXV) + 64'd1) ? SAMPLE_BITS'(SMINV)
                                                      : SAMPLE_BITS'(64'd0 - avg_q);
      else
        average <= (avg_q > $unsigned(SMAXV)) ? SAMPLE_BITS'(SMAXV) : SAMPLE_BITS'(avg_q);
      if (!cnt_gt1) std_dev <= '0;
      else std_dev <= (sq_res > $unsigned(SMAXV)) ? (SAMPLE_BITS-1)'(SMAXV)
                                                  : (SAMPLE_BITS-1)'(sq_res);
    end
  end

endmodule

>>> sv/running_mean_stddev_min_max.sv
// Running statistics over signed fixed-point samples. Each input beat is either
// a sample or a clear command, and each returns one beat with count, minimum,
// maximum, average, sample standard deviation and a sticky overflow flag. One
// beat at a time is processed: a sample takes four passes of the shared
// one-bit-a-cycle 128-bit divider and a clear or a dropped sample two; the
// square root follows, plus any wait on the result side. Depends on rmsd_pkg,
// rmsd_if, rmsd_ctrl and rmsd_dp.
module running_mean_stddev_min_max
  import rmsd_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_BITS  = 32
) (
  input logic clk,
  input logic rst,
  rmsd_if.sink   in_ch,
  rmsd_if.source out_ch
);

  rmsd_cmd_t    cmd;
  rmsd_status_t status;

  rmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.data.mode),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  rmsd_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (in_ch.data.sample),
    .sample_count(out_ch.data.sample_count),
    .minimum     (out_ch.data.minimum),
    .maximum     (out_ch.data.maximum),
    .average     (out_ch.data.average),
    .std_dev     (out_ch.data.std_dev),
    .overflow    (out_ch.data.overflow)
  );

endmodule
